// ===== src/evsm_pkg.sv =====
`timescale 1ns / 1ps
package evsm_pkg;

    // default sizes
    localparam int P_VOICES             = 8;
    localparam int P_SAMPLE_STORE_BYTES = 65536;
    localparam int P_MAX_SOUNDS         = 256;
    localparam int P_FRAMES_PER_BLOCK   = 512;

    // request codes
    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_PLAY = 2'd1,
        REQ_TICK = 2'd2
    } req_t;

    // register indexes
    localparam logic CFG_MASTER_VOLUME = 1'b0;
    localparam logic CFG_EIGHT_BIT     = 1'b1;

    // result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ACK   = 1'b1;

    localparam logic [15:0] HANDLE_FIRST        = 16'd100;
    localparam logic [4:0]  MASTER_VOLUME_RESET = 5'd31;
    localparam logic [7:0]  SAMPLE_ZERO         = 8'd128;
    localparam logic [8:0]  PAN_SPAN            = 9'd257;
    // x/31 as (x*4229)>>17 for x below 4096
    localparam logic [12:0] RECIP_31            = 13'd4229;
    // x/127 as (x*8454661)>>30 for x below 2^22
    localparam logic [23:0] RECIP_127           = 24'd8454661;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAY_EXCL,
        ST_PLAY_SCAN,
        ST_PLAY_FIN,
        ST_TICK_RUN,
        ST_TICK_DRAIN,
        ST_TICK_FIN
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic capture;
        logic excl;
        logic scan;
        logic play_fin;
        logic tick_start;
        logic issue;
        logic tick_fin;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic busy;
        logic out_free;
    } stat_t;

    typedef logic [17:0] step_rom_t [64];

    // (a*b)>>60, low 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // floor(2^(m/64) * 2^17) in Q60 fixed point, series for ln2 and exp
    function automatic step_rom_t build_step_rom();
        step_rom_t   rom;
        logic [63:0] ln2;
        logic [63:0] xstep;
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        ln2 = 64'd0;
        for (int k = 1; k <= 60; k++)
        begin
            ln2 = ln2 + ((64'd1 << (60 - k)) / 64'(k));
        end
        xstep = ln2 >> 6;
        for (int m = 0; m < 64; m++)
        begin
            x    = xstep * 64'(m);
            sum  = 64'd1 << 60;
            term = 64'd1 << 60;
            for (int n = 1; n <= 40; n++)
            begin
                term = mul_q60(term, x) / 64'(n);
                sum  = sum + term;
            end
            rom[m] = sum[60:43];
        end
        return rom;
    endfunction

    localparam step_rom_t STEP_ROM = build_step_rom();

endpackage

// ===== src/evsm_ctrl.sv =====
`timescale 1ns / 1ps
module evsm_ctrl #(
    parameter int VOICES = evsm_pkg::P_VOICES,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    output evsm_pkg::cmd_t    cmd,
    output logic [VW-1:0]     idx,
    input  evsm_pkg::stat_t   stat
);
    import evsm_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    logic [VW-1:0] idx_reg;
    logic [VW-1:0] idx_next;
    logic          idx_last;

    assign idx_last = (idx_reg == VW'(VOICES - 1));
    assign idx      = idx_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (req_type)
                        REQ_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        REQ_PLAY:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_PLAY_EXCL;
                        end
                        REQ_TICK:
                        begin
                            cmd.capture    = 1'b1;
                            cmd.tick_start = 1'b1;
                            idx_next       = '0;
                            state_next     = ST_TICK_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PLAY_EXCL:
            begin
                cmd.excl   = 1'b1;
                idx_next   = '0;
                state_next = ST_PLAY_SCAN;
            end
            ST_PLAY_SCAN:
            begin
                cmd.scan = 1'b1;
                if (idx_last)
                    state_next = ST_PLAY_FIN;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_PLAY_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.play_fin = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK_RUN:
            begin
                cmd.issue = 1'b1;
                if (idx_last)
                    state_next = ST_TICK_DRAIN;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_TICK_DRAIN:
            begin
                if (!stat.busy)
                    state_next = ST_TICK_FIN;
            end
            ST_TICK_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.tick_fin = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // mix pipeline is empty whenever a new word can come in
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !stat.busy)
        else $error("mix pipeline busy in idle");

    a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK_FIN) |-> !stat.busy)
        else $error("frame finished before pipeline drained");

    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue || cmd.scan) |-> (32'(idx_reg) < VOICES))
        else $error("voice index out of range");

endmodule

// ===== src/evsm_dp.sv =====
`timescale 1ns / 1ps
module evsm_dp #(
    parameter int VOICES             = evsm_pkg::P_VOICES,
    parameter int SAMPLE_STORE_BYTES = evsm_pkg::P_SAMPLE_STORE_BYTES,
    parameter int MAX_SOUNDS         = evsm_pkg::P_MAX_SOUNDS,
    parameter int FRAMES_PER_BLOCK   = evsm_pkg::P_FRAMES_PER_BLOCK,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  evsm_pkg::cmd_t   cmd,
    input  logic [VW-1:0]    idx,
    output evsm_pkg::stat_t  stat,
    input  logic             cfg_write_en,
    input  logic             cfg_index,
    input  logic [4:0]       cfg_data,
    input  logic [7:0]       data_byte,
    input  logic             end_of_sound,
    input  logic [7:0]       sound_id,
    input  logic [7:0]       pitch,
    input  logic [6:0]       volume,
    input  logic [7:0]       separation,
    input  logic             exclusive,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             result_kind,
    output logic [15:0]      left_sample,
    output logic [15:0]      right_sample,
    output logic [7:0]       mono_byte,
    output logic [15:0]      voice_handle,
    output logic [2:0]       voice_slot
);
    import evsm_pkg::*;

    localparam int AW    = $clog2(SAMPLE_STORE_BYTES);
    localparam int LW    = AW + 1;
    localparam int TW    = $clog2(MAX_SOUNDS);
    localparam int SW    = TW + 1;
    localparam int FW    = $clog2(FRAMES_PER_BLOCK + 1);
    localparam int ACC_W = 18 + VW;
    localparam logic signed [ACC_W+2:0] SAT_HI = 32767;
    localparam logic signed [ACC_W+2:0] SAT_LO = -32768;

    // configuration
    logic [4:0] mv_reg;
    logic       eb_reg;

    // loader
    logic [LW-1:0] la_reg;
    logic [SW-1:0] sl_reg;
    logic [LW-1:0] cur_len_reg;
    logic [AW-1:0] cur_base_reg;
    logic          can_load;
    logic          store_ok;
    logic [AW-1:0] base_sel;
    logic [LW-1:0] len_inc;

    // memories
    logic [7:0]       store_mem [SAMPLE_STORE_BYTES];
    logic [LW+AW-1:0] tbl_mem [MAX_SOUNDS];
    logic [7:0]       rd_q;
    logic [LW+AW-1:0] tbl_q;
    logic [AW-1:0]    rd_addr;

    // play word
    logic [7:0]  id_reg;
    logic [7:0]  pitch_reg;
    logic [6:0]  vol_reg;
    logic [8:0]  s_reg;
    logic        excl_reg;
    logic [16:0] sql_reg;
    logic [16:0] sqr_reg;
    logic [6:0]  gl_reg;
    logic [6:0]  gr_reg;
    logic [8:0]  sr_diff;
    logic [23:0] pan_l;
    logic [23:0] pan_r;

    // voices
    logic          act_reg   [VOICES];
    logic [LW-1:0] pos_reg   [VOICES];
    logic [LW-1:0] end_reg   [VOICES];
    logic [15:0]   frac_reg  [VOICES];
    logic [17:0]   step_reg  [VOICES];
    logic [31:0]   start_reg [VOICES];
    logic [7:0]    snd_reg   [VOICES];
    logic [6:0]    vgl_reg   [VOICES];
    logic [6:0]    vgr_reg   [VOICES];

    // exclusion and slot search
    logic          ex_hit;
    logic [VW-1:0] ex_idx;
    logic          free_found_reg;
    logic [VW-1:0] free_slot_reg;
    logic [31:0]   oldest_reg;
    logic [VW-1:0] oldest_slot_reg;
    logic [VW-1:0] slot;

    // play finish values
    logic [9:0]    id_ext;
    logic [9:0]    sl_ext;
    logic [LW-1:0] snd_len;
    logic [AW-1:0] snd_base;
    logic [LW-1:0] end_val;
    logic [17:0]   step_val;
    logic [15:0]   handle;
    logic [7:0]    slot_wide;

    // tick voice visit
    logic          v_act;
    logic [LW-1:0] v_pos;
    logic [LW-1:0] v_end;
    logic          v_ok;
    logic [18:0]   fsum;
    logic [LW:0]   pos_new;
    logic          v_still;

    // mix pipeline
    logic          s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [11:0]   s1_pl_reg, s1_pr_reg;
    logic          s2_neg_reg, s3_neg_reg, s4_neg_reg;
    logic [7:0]    s2_mag_reg;
    logic [6:0]    s2_gl_reg, s2_gr_reg;
    logic [14:0]   s3_yl_reg, s3_yr_reg;
    logic [15:0]   s4_ql_reg, s4_qr_reg;
    logic [24:0]   gsc_l;
    logic [24:0]   gsc_r;
    logic [46:0]   qp_l;
    logic [46:0]   qp_r;
    logic signed [ACC_W-1:0] acc_l_reg;
    logic signed [ACC_W-1:0] acc_r_reg;
    logic signed [ACC_W-1:0] ql_ext;
    logic signed [ACC_W-1:0] qr_ext;

    // frame output
    logic [15:0] sat_l;
    logic [15:0] sat_r;
    logic [16:0] mono_sum;

    // counters
    logic [15:0]   hc_reg;
    logic [31:0]   bt_reg;
    logic [FW-1:0] fib_reg;
    logic [FW-1:0] fib_inc;

    // output register
    logic        ov_reg;
    logic        kind_reg;
    logic [15:0] left_reg;
    logic [15:0] right_reg;
    logic [7:0]  mono_reg;
    logic [15:0] handle_reg;
    logic [2:0]  slot_reg;

    logic pos_bad;

    function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W+2:0] sh;
        sh = {a, 3'b000};
        if (sh > SAT_HI)
            return 16'h7fff;
        else if (sh < SAT_LO)
            return 16'h8000;
        else
            return sh[15:0];
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= MASTER_VOLUME_RESET;
            eb_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MASTER_VOLUME: mv_reg <= cfg_data;
                CFG_EIGHT_BIT:     eb_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // load bookkeeping
    assign can_load = (sl_reg < SW'(MAX_SOUNDS));
    assign store_ok = (la_reg < LW'(SAMPLE_STORE_BYTES));
    assign base_sel = (cur_len_reg == '0) ? la_reg[AW-1:0] : cur_base_reg;
    assign len_inc  = cur_len_reg + (store_ok ? LW'(1) : LW'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_reg      <= '0;
            sl_reg      <= '0;
            cur_len_reg <= '0;
        end
        else if (cmd.load && can_load)
        begin
            if (store_ok)
                la_reg <= la_reg + 1'b1;
            if (end_of_sound)
            begin
                sl_reg      <= sl_reg + 1'b1;
                cur_len_reg <= '0;
            end
            else
                cur_len_reg <= len_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && can_load)
            cur_base_reg <= base_sel;
    end

    // sample store and sound table
    always_ff @(posedge clk)
    begin
        if (cmd.load && can_load && store_ok)
            store_mem[la_reg[AW-1:0]] <= data_byte;
        rd_q <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && can_load && end_of_sound)
            tbl_mem[sl_reg[TW-1:0]] <= {len_inc, base_sel};
        tbl_q <= tbl_mem[id_reg[TW-1:0]];
    end

    // play word capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            id_reg    <= sound_id;
            pitch_reg <= pitch;
            vol_reg   <= volume;
            s_reg     <= {1'b0, separation} + 9'd1;
            excl_reg  <= exclusive;
        end
    end

    // squared pan law over two stages
    assign sr_diff = PAN_SPAN - s_reg;
    assign pan_l   = {17'd0, vol_reg} * {7'd0, sql_reg};
    assign pan_r   = {17'd0, vol_reg} * {7'd0, sqr_reg};

    always_ff @(posedge clk)
    begin
        sql_reg <= 17'({8'd0, s_reg} * {8'd0, s_reg});
        sqr_reg <= 17'({8'd0, sr_diff} * {8'd0, sr_diff});
        gl_reg  <= vol_reg - pan_l[22:16];
        gr_reg  <= vol_reg - pan_r[22:16];
    end

    // first active voice on the same sound
    always_comb
    begin
        ex_hit = 1'b0;
        ex_idx = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            if (!ex_hit && act_reg[i] && (snd_reg[i] == id_reg))
            begin
                ex_hit = 1'b1;
                ex_idx = VW'(i);
            end
        end
    end

    // slot search, one voice a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.excl)
        begin
            free_found_reg  <= 1'b0;
            oldest_reg      <= bt_reg;
            oldest_slot_reg <= '0;
        end
        else if (cmd.scan)
        begin
            if (!act_reg[idx] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= idx;
            end
            else if (act_reg[idx] && (start_reg[idx] < oldest_reg))
            begin
                oldest_reg      <= start_reg[idx];
                oldest_slot_reg <= idx;
            end
        end
    end

    assign slot = free_found_reg ? free_slot_reg : oldest_slot_reg;

    // sound lookup for the new voice
    assign id_ext = 10'(id_reg);
    assign sl_ext = 10'(sl_reg);

    always_comb
    begin
        if ((id_ext >= 10'(MAX_SOUNDS)) || (id_ext > sl_ext))
        begin
            snd_len  = '0;
            snd_base = '0;
        end
        else if (id_ext == sl_ext)
        begin
            snd_len  = cur_len_reg;
            snd_base = cur_base_reg;
        end
        else
        begin
            snd_len  = tbl_q[LW+AW-1:AW];
            snd_base = tbl_q[AW-1:0];
        end
        if (snd_len == '0)
            snd_base = '0;
    end

    assign end_val   = {1'b0, snd_base} + snd_len;
    assign step_val  = STEP_ROM[pitch_reg[5:0]] >> (2'd3 - pitch_reg[7:6]);
    assign handle    = (hc_reg == '0) ? HANDLE_FIRST : hc_reg;
    assign slot_wide = 8'(slot);

    // voice visit during a frame
    assign v_act   = act_reg[idx];
    assign v_pos   = pos_reg[idx];
    assign v_end   = end_reg[idx];
    assign v_ok    = v_act && (v_pos < v_end) && (v_pos < LW'(SAMPLE_STORE_BYTES));
    assign rd_addr = v_pos[AW-1:0];
    assign fsum    = {3'd0, frac_reg[idx]} + {1'b0, step_reg[idx]};
    assign pos_new = {1'b0, v_pos} + (LW+1)'(fsum[18:16]);
    assign v_still = (pos_new < {1'b0, v_end});

    // voice active flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
                act_reg[i] <= 1'b0;
        end
        else
        begin
            if (cmd.excl && excl_reg && ex_hit)
                act_reg[ex_idx] <= 1'b0;
            if (cmd.play_fin)
                act_reg[slot] <= 1'b1;
            if (cmd.issue && v_act)
                act_reg[idx] <= v_ok && v_still;
        end
    end

    // voice fields
    always_ff @(posedge clk)
    begin
        if (cmd.play_fin)
        begin
            pos_reg[slot]   <= {1'b0, snd_base};
            end_reg[slot]   <= end_val;
            frac_reg[slot]  <= '0;
            step_reg[slot]  <= step_val;
            start_reg[slot] <= bt_reg;
            snd_reg[slot]   <= id_reg;
            vgl_reg[slot]   <= gl_reg;
            vgr_reg[slot]   <= gr_reg;
        end
        if (cmd.issue && v_ok)
        begin
            frac_reg[idx] <= fsum[15:0];
            pos_reg[idx]  <= pos_new[LW-1:0];
        end
    end

    // mix pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.issue && v_ok;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    assign gsc_l  = {13'd0, s1_pl_reg} * {12'd0, RECIP_31};
    assign gsc_r  = {13'd0, s1_pr_reg} * {12'd0, RECIP_31};
    assign qp_l   = {24'd0, s3_yl_reg, 8'd0} * {23'd0, RECIP_127};
    assign qp_r   = {24'd0, s3_yr_reg, 8'd0} * {23'd0, RECIP_127};
    assign ql_ext = $signed({{(ACC_W-16){1'b0}}, s4_ql_reg});
    assign qr_ext = $signed({{(ACC_W-16){1'b0}}, s4_qr_reg});

    // master volume, signed scaling, accumulation
    always_ff @(posedge clk)
    begin
        s1_pl_reg  <= 12'({5'd0, vgl_reg[idx]} * {7'd0, mv_reg});
        s1_pr_reg  <= 12'({5'd0, vgr_reg[idx]} * {7'd0, mv_reg});
        s2_neg_reg <= (rd_q < SAMPLE_ZERO);
        s2_mag_reg <= (rd_q < SAMPLE_ZERO) ? (SAMPLE_ZERO - rd_q) : (rd_q - SAMPLE_ZERO);
        s2_gl_reg  <= gsc_l[23:17];
        s2_gr_reg  <= gsc_r[23:17];
        s3_neg_reg <= s2_neg_reg;
        s3_yl_reg  <= 15'({8'd0, s2_gl_reg} * {7'd0, s2_mag_reg});
        s3_yr_reg  <= 15'({8'd0, s2_gr_reg} * {7'd0, s2_mag_reg});
        s4_neg_reg <= s3_neg_reg;
        s4_ql_reg  <= qp_l[45:30];
        s4_qr_reg  <= qp_r[45:30];
        if (cmd.tick_start)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (s4_v_reg)
        begin
            acc_l_reg <= s4_neg_reg ? (acc_l_reg - ql_ext) : (acc_l_reg + ql_ext);
            acc_r_reg <= s4_neg_reg ? (acc_r_reg - qr_ext) : (acc_r_reg + qr_ext);
        end
    end

    assign stat.busy     = s1_v_reg | s2_v_reg | s3_v_reg | s4_v_reg;
    assign stat.out_free = !ov_reg || out_ready;

    // frame formatting
    assign sat_l    = sat16(acc_l_reg);
    assign sat_r    = sat16(acc_r_reg);
    assign mono_sum = {1'b0, ~sat_l[15], sat_l[14:0]} + {1'b0, ~sat_r[15], sat_r[14:0]};
    assign fib_inc  = fib_reg + 1'b1;

    // handle counter and frame timing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg  <= '0;
            bt_reg  <= 32'd1;
            fib_reg <= '0;
        end
        else
        begin
            if (cmd.play_fin)
                hc_reg <= handle + 16'd1;
            if (cmd.tick_fin)
            begin
                if (fib_inc == FW'(FRAMES_PER_BLOCK))
                begin
                    fib_reg <= '0;
                    bt_reg  <= bt_reg + 32'd1;
                end
                else
                    fib_reg <= fib_inc;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.play_fin || cmd.tick_fin)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.play_fin)
        begin
            kind_reg   <= KIND_ACK;
            left_reg   <= '0;
            right_reg  <= '0;
            mono_reg   <= '0;
            handle_reg <= handle;
            slot_reg   <= slot_wide[2:0];
        end
        else if (cmd.tick_fin)
        begin
            kind_reg   <= KIND_FRAME;
            left_reg   <= eb_reg ? 16'd0 : sat_l;
            right_reg  <= eb_reg ? 16'd0 : sat_r;
            mono_reg   <= eb_reg ? mono_sum[16:9] : 8'd0;
            handle_reg <= '0;
            slot_reg   <= '0;
        end
    end

    assign out_valid    = ov_reg;
    assign result_kind  = kind_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;
    assign mono_byte    = mono_reg;
    assign voice_handle = handle_reg;
    assign voice_slot   = slot_reg;

    // active voices never sit past their end
    always_comb
    begin
        pos_bad = 1'b0;
        for (int i = 0; i < VOICES; i++)
        begin
            if (act_reg[i] && (pos_reg[i] > end_reg[i]))
                pos_bad = 1'b1;
        end
    end

    a_pos_in_sound: assert property (@(posedge clk) disable iff (!rst_n) !pos_bad)
        else $error("active voice beyond sound end");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        la_reg <= LW'(SAMPLE_STORE_BYTES))
        else $error("load address beyond store");

    a_sound_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (sl_reg <= SW'(MAX_SOUNDS)))
        else $error("sound count beyond table");

endmodule

// ===== src/eight_voice_sample_mixer.sv =====
`timescale 1ns / 1ps
// Eight-voice PCM sample mixer. A load word appends a byte to the sample store;
// a play word runs a slot search that visits one voice a cycle; a tick word
// issues one voice a cycle into a gain and scaling pipeline that reads the
// sample store read port. One word is worked on at a time; a result waits in
// an output register and a finished word is only held back while that register
// is still full. There is no clearing pass after reset. Configuration must be
// written while the block is idle; the block itself does not enforce this.
module eight_voice_sample_mixer #(
    parameter int VOICES             = evsm_pkg::P_VOICES,
    parameter int SAMPLE_STORE_BYTES = evsm_pkg::P_SAMPLE_STORE_BYTES,
    parameter int MAX_SOUNDS         = evsm_pkg::P_MAX_SOUNDS,
    parameter int FRAMES_PER_BLOCK   = evsm_pkg::P_FRAMES_PER_BLOCK
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    input  logic        end_of_sound,
    input  logic [7:0]  sound_id,
    input  logic [7:0]  pitch,
    input  logic [6:0]  volume,
    input  logic [7:0]  separation,
    input  logic        exclusive,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [15:0] left_sample,
    output logic [15:0] right_sample,
    output logic [7:0]  mono_byte,
    output logic [15:0] voice_handle,
    output logic [2:0]  voice_slot
);
    import evsm_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    cmd_t          cmd;
    stat_t         stat;
    logic [VW-1:0] idx;

    // sequencer
    evsm_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .cmd      (cmd),
        .idx      (idx),
        .stat     (stat)
    );

    // storage, voices and mix pipeline
    evsm_dp #(
        .VOICES             (VOICES),
        .SAMPLE_STORE_BYTES (SAMPLE_STORE_BYTES),
        .MAX_SOUNDS         (MAX_SOUNDS),
        .FRAMES_PER_BLOCK   (FRAMES_PER_BLOCK)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .idx          (idx),
        .stat         (stat),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (data_byte),
        .end_of_sound (end_of_sound),
        .sound_id     (sound_id),
        .pitch        (pitch),
        .volume       (volume),
        .separation   (separation),
        .exclusive    (exclusive),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .result_kind  (result_kind),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .mono_byte    (mono_byte),
        .voice_handle (voice_handle),
        .voice_slot   (voice_slot)
    );

endmodule

// ===== test/tb_eight_voice_sample_mixer.sv =====
`timescale 1ns / 1ps
module tb_eight_voice_sample_mixer;
    import evsm_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 4000000;
    localparam int         HOLD_CYCLES = 400;

    typedef struct {
        logic        kind;
        logic [15:0] left;
        logic [15:0] right;
        logic [7:0]  mono;
        logic [15:0] handle;
        logic [2:0]  slot;
    } mix_result_t;

    // predicts mixer results and holds the ones still owed
    class mixer_scoreboard;
        logic [31:0] pitch_table [64];
        logic [7:0]  store [0:65535];
        int unsigned snd_base [256];
        int unsigned snd_len [256];
        int unsigned load_addr;
        int unsigned sounds_loaded;
        bit          v_on [8];
        int unsigned v_pos [8];
        int unsigned v_end [8];
        int unsigned v_frac [8];
        int unsigned v_step [8];
        int unsigned v_start [8];
        int unsigned v_snd [8];
        int unsigned v_lg [8];
        int unsigned v_rg [8];
        int unsigned next_handle;
        int unsigned block_time;
        int unsigned frame_cnt;
        int unsigned master_vol;
        bit          byte_mode;
        mix_result_t owed [$];
        int          errors;
        int          frames_seen;
        int          acks_seen;

        function new();
            logic [63:0]  ln2;
            logic [63:0]  x;
            logic [63:0]  acc;
            logic [63:0]  term;
            logic [127:0] prod;
            ln2 = 0;
            for (int k = 1; k <= 60; k++)
            begin
                ln2 += (64'd1 << (60 - k)) / 64'(k);
            end
            for (int m = 0; m < 64; m++)
            begin
                x = (ln2 >> 6) * 64'(m);
                acc = 64'd1 << 60;
                term = 64'd1 << 60;
                for (int n = 1; n <= 40; n++)
                begin
                    prod = {64'd0, term} * {64'd0, x};
                    term = prod[123:60] / 64'(n);
                    acc += term;
                end
                pitch_table[m] = 32'(acc >> 43);
            end
            for (int a = 0; a < 65536; a++)
            begin
                store[a] = 8'd0;
            end
            foreach (snd_len[s])
            begin
                snd_len[s] = 0;
                snd_base[s] = 0;
            end
            for (int v = 0; v < 8; v++)
            begin
                v_on[v] = 0; v_pos[v] = 0; v_end[v] = 0; v_frac[v] = 0; v_step[v] = 0;
                v_start[v] = 0; v_snd[v] = 0; v_lg[v] = 0; v_rg[v] = 0;
            end
            load_addr = 0; sounds_loaded = 0; next_handle = 0;
            block_time = 1; frame_cnt = 0; master_vol = 31; byte_mode = 0;
            errors = 0; frames_seen = 0; acks_seen = 0;
        endfunction

        function void set_reg(logic idx, logic [4:0] val);
            if (idx == CFG_MASTER_VOLUME)
                master_vol = val;
            else
                byte_mode = val[0];
        endfunction

        function int unsigned pan(int unsigned v, int s);
            return v - (int'(v) * (s * s)) / 65536;
        endfunction

        function int scaled(int unsigned g, logic [7:0] b);
            int d;
            int mag;
            d = int'(b) - 128;
            mag = (int'(g) * (d < 0 ? -d : d) * 256) / 127;
            return d < 0 ? -mag : mag;
        endfunction

        function int sat(int x);
            return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
        endfunction

        // an accepted input word, with its expected result if any
        function void note_word(logic [1:0] req, logic [7:0] dbyte, logic eos, logic [7:0] id,
                                logic [7:0] p, logic [6:0] vol, logic [7:0] sep, logic excl);
            mix_result_t r;
            int unsigned oldest;
            int unsigned oldest_slot;
            int unsigned slot;
            int unsigned len;
            int unsigned base;
            int          i;
            int          dl;
            int          dr;
            int unsigned ul;
            int unsigned ur;
            r = '{kind: KIND_FRAME, left: 0, right: 0, mono: 0, handle: 0, slot: 0};
            if (req == REQ_LOAD)
            begin
                if (sounds_loaded < 256)
                begin
                    if (snd_len[sounds_loaded] == 0)
                        snd_base[sounds_loaded] = load_addr;
                    if (load_addr < 65536)
                    begin
                        store[load_addr] = dbyte;
                        load_addr++;
                        snd_len[sounds_loaded]++;
                    end
                    if (eos)
                        sounds_loaded++;
                end
            end
            else if (req == REQ_PLAY)
            begin
                if (excl)
                begin
                    for (i = 0; i < 8; i++)
                    begin
                        if (v_on[i] && v_snd[i] == id)
                        begin
                            v_on[i] = 0;
                            break;
                        end
                    end
                end
                oldest = block_time;
                oldest_slot = 0;
                for (i = 0; i < 8 && v_on[i]; i++)
                begin
                    if (v_start[i] < oldest)
                    begin
                        oldest_slot = i;
                        oldest = v_start[i];
                    end
                end
                slot = (i == 8) ? oldest_slot : i;
                len = snd_len[id];
                base = (len != 0) ? snd_base[id] : 0;
                if (next_handle == 0)
                    next_handle = 100;
                r.kind = KIND_ACK;
                r.handle = next_handle[15:0];
                r.slot = slot[2:0];
                next_handle = (next_handle + 1) & 16'hffff;
                v_on[slot] = 1;
                v_pos[slot] = base;
                v_end[slot] = base + len;
                v_frac[slot] = 0;
                v_step[slot] = pitch_table[p[5:0]] >> (3 - p[7:6]);
                v_start[slot] = block_time;
                v_snd[slot] = id;
                v_lg[slot] = pan(vol, int'(sep) + 1);
                v_rg[slot] = pan(vol, int'(sep) + 1 - 257);
                owed.push_back(r);
            end
            else if (req == REQ_TICK)
            begin
                dl = 0;
                dr = 0;
                for (i = 0; i < 8; i++)
                begin
                    if (!v_on[i])
                        continue;
                    if (v_pos[i] >= v_end[i] || v_pos[i] >= 65536)
                    begin
                        v_on[i] = 0;
                        continue;
                    end
                    dl += scaled(v_lg[i] * master_vol / 31, store[v_pos[i]]);
                    dr += scaled(v_rg[i] * master_vol / 31, store[v_pos[i]]);
                    v_frac[i] += v_step[i];
                    v_pos[i] += v_frac[i] >> 16;
                    v_frac[i] &= 16'hffff;
                    if (v_pos[i] >= v_end[i])
                        v_on[i] = 0;
                end
                dl = sat(dl * 8);
                dr = sat(dr * 8);
                if (byte_mode)
                begin
                    ul = (dl ^ 32'h8000) & 16'hffff;
                    ur = (dr ^ 32'h8000) & 16'hffff;
                    r.mono = 8'(((ul + ur) / 2) >> 8);
                end
                else
                begin
                    r.left = dl[15:0];
                    r.right = dr[15:0];
                end
                owed.push_back(r);
                frame_cnt++;
                if (frame_cnt >= 512)
                begin
                    frame_cnt = 0;
                    block_time++;
                end
            end
        endfunction

        function void mismatch(string what, logic [15:0] exp_v, logic [15:0] act_v);
            errors++;
            if (errors <= 30)
                $display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
        endfunction

        // compare one delivered word with the oldest prediction
        function void check_result(mix_result_t act);
            mix_result_t e;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= 30)
                    $display("%0t: unexpected result word kind %0d", $time, act.kind);
                return;
            end
            e = owed.pop_front();
            if (act.kind == KIND_ACK) acks_seen++; else frames_seen++;
            if (act.kind !== e.kind) mismatch("result_kind", e.kind, act.kind);
            if (act.left !== e.left) mismatch("left_sample", e.left, act.left);
            if (act.right !== e.right) mismatch("right_sample", e.right, act.right);
            if (act.mono !== e.mono) mismatch("mono_byte", e.mono, act.mono);
            if (act.handle !== e.handle) mismatch("voice_handle", e.handle, act.handle);
            if (act.slot !== e.slot) mismatch("voice_slot", e.slot, act.slot);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic        cfg_index;
    logic [4:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic        end_of_sound;
    logic [7:0]  sound_id;
    logic [7:0]  pitch;
    logic [6:0]  volume;
    logic [7:0]  separation;
    logic        exclusive;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [15:0] left_sample;
    logic [15:0] right_sample;
    logic [7:0]  mono_byte;
    logic [15:0] voice_handle;
    logic [2:0]  voice_slot;

    mixer_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_left;
    bit  hold_req;
    bit  hold_done;
    int  cycles;

    eight_voice_sample_mixer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .data_byte    (data_byte),
        .end_of_sound (end_of_sound),
        .sound_id     (sound_id),
        .pitch        (pitch),
        .volume       (volume),
        .separation   (separation),
        .exclusive    (exclusive),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .mono_byte    (mono_byte),
        .voice_handle (voice_handle),
        .voice_slot   (voice_slot)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver side, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result word check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{kind: result_kind, left: left_sample, right: right_sample,
                              mono: mono_byte, handle: voice_handle, slot: voice_slot});
    end

    // offer one input word and note it once accepted
    task automatic send_word(logic [1:0] req, logic [7:0] dbyte, logic eos, logic [7:0] id,
                             logic [7:0] p, logic [6:0] vol, logic [7:0] sep, logic excl);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        data_byte <= dbyte;
        end_of_sound <= eos;
        sound_id <= id;
        pitch <= p;
        volume <= vol;
        separation <= sep;
        exclusive <= excl;
        do @(posedge clk); while (!in_ready);
        sb.note_word(req, dbyte, eos, id, p, vol, sep, excl);
    endtask

    task automatic load_byte(logic [7:0] b, logic eos);
        send_word(REQ_LOAD, b, eos, 8'($urandom), 8'($urandom), 7'($urandom),
                  8'($urandom), 1'($urandom));
    endtask

    task automatic play(logic [7:0] id, logic [7:0] p, logic [6:0] vol, logic [7:0] sep,
                        logic excl);
        send_word(REQ_PLAY, 8'($urandom), 1'($urandom), id, p, vol, sep, excl);
    endtask

    task automatic tick();
        send_word(REQ_TICK, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                  7'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // let every owed result arrive and the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_write_en <= 1'b0;
    endtask

    // mostly well-formed traffic: short sounds, plays on them, plenty of ticks
    task automatic random_traffic(int count);
        int pick;
        int len;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 12 && sb.sounds_loaded < 250)
            begin
                len = $urandom_range(1, 40);
                for (int b = 0; b < len; b++)
                    load_byte(8'($urandom), b == len - 1);
            end
            else if (pick < 40)
                play((($urandom_range(9) < 8) ? 8'($urandom_range(sb.sounds_loaded))
                                              : 8'($urandom)),
                     8'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
            else if (pick < 98)
                tick();
            else
                send_word(REQ_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom),
                          8'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    // stimulus
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cycles = 0;
        hold_left = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_MASTER_VOLUME;
        cfg_data = 5'd0;
        in_valid = 1'b0;
        req_type = REQ_LOAD;
        data_byte = 8'd0;
        end_of_sound = 1'b0;
        sound_id = 8'd0;
        pitch = 8'd0;
        volume = 7'd0;
        separation = 8'd0;
        exclusive = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme bytes, pan and pitch ends, exclusive, empty sound, unused code
        load_byte(8'd0, 1'b0);
        load_byte(8'd255, 1'b0);
        load_byte(8'd128, 1'b1);
        load_byte(8'd255, 1'b1);
        play(8'd0, 8'd128, 7'd127, 8'd0, 1'b0);
        play(8'd0, 8'd255, 7'd127, 8'd255, 1'b1);
        play(8'd1, 8'd0, 7'd0, 8'd127, 1'b0);
        play(8'd200, 8'd64, 7'd127, 8'd128, 1'b0);
        send_word(REQ_UNUSED, 8'hff, 1'b1, 8'hff, 8'hff, 7'h7f, 8'hff, 1'b1);
        tick();
        tick();
        for (int v = 0; v < 9; v++)
            play(8'd1, 8'd192, 7'd100, 8'(v * 31), 1'b0);
        tick();
        tick();
        tick();
        tick();
        drain();

        // sender idles 28%, receiver 88%
        write_reg(CFG_MASTER_VOLUME, 5'd0);
        write_reg(CFG_EIGHT_BIT, 5'd0);
        send_idle_pct = 28;
        recv_idle_pct = 88;
        random_traffic(35);
        drain();

        // ticks up to the block boundary so start times fall behind block time
        write_reg(CFG_MASTER_VOLUME, 5'd31);
        write_reg(CFG_EIGHT_BIT, 5'd1);
        send_idle_pct = 88;
        recv_idle_pct = 28;
        random_traffic(35);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sb.block_time == 1)
            tick();
        for (int v = 0; v < 10; v++)
            play(8'($urandom_range(sb.sounds_loaded)), 8'($urandom), 7'($urandom),
                 8'($urandom), 1'b0);
        drain();

        // no idling, one long receiver hold-off while words keep coming
        write_reg(CFG_MASTER_VOLUME, 5'($urandom_range(1, 30)));
        write_reg(CFG_EIGHT_BIT, 5'd0);
        hold_req <= 1'b1;
        random_traffic(35);
        drain();

        // plays on sounds never loaded, each followed by a frame
        write_reg(CFG_MASTER_VOLUME, 5'd31);
        for (int v = 0; v < 12; v++)
        begin
            play(8'($urandom_range(200, 255)), 8'($urandom), 7'($urandom), 8'($urandom),
                 1'($urandom));
            tick();
        end
        drain();

        $display("frames checked: %0d, play acknowledgements checked: %0d",
                 sb.frames_seen, sb.acks_seen);
        $display("%0d sample bytes loaded, %0d sounds registered", sb.load_addr,
                 sb.sounds_loaded);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
